// ===== rtl/c_subset_tokenizer_core_defines.svh =====
// assertion macros shared by the tokenizer rtl
// expects clk and arst_n in the scope of each use
`ifndef C_SUBSET_TOKENIZER_CORE_DEFINES_SVH
`define C_SUBSET_TOKENIZER_CORE_DEFINES_SVH

// property that holds at every edge outside reset
`define CTOK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define CTOK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ctok_pkg.sv =====
// types, token codes and character classifiers for the tokenizer
// no dependencies; used by ctok_lex, ctok_outq and the top module
package ctok_pkg;

	localparam int POS_W   = 32;
	localparam int LEN_MAX = 255;
	localparam int LEN_W   = $clog2(LEN_MAX + 1);

	typedef logic [4:0] kind_t;
	typedef logic [2:0] op_t;
	typedef logic [3:0] kw_t;

	// token kinds
	localparam kind_t TK_LBRACE  = 5'd0;
	localparam kind_t TK_RBRACE  = 5'd1;
	localparam kind_t TK_LPAREN  = 5'd2;
	localparam kind_t TK_RPAREN  = 5'd3;
	localparam kind_t TK_SEMI    = 5'd4;
	localparam kind_t TK_RETURN  = 5'd5;
	localparam kind_t TK_INT     = 5'd6;
	localparam kind_t TK_LITERAL = 5'd7;
	localparam kind_t TK_MINUS   = 5'd8;
	localparam kind_t TK_TILDE   = 5'd9;
	localparam kind_t TK_NOT     = 5'd10;
	localparam kind_t TK_PLUS    = 5'd11;
	localparam kind_t TK_STAR    = 5'd12;
	localparam kind_t TK_SLASH   = 5'd13;
	localparam kind_t TK_AND     = 5'd14;
	localparam kind_t TK_OR      = 5'd15;
	localparam kind_t TK_ASSIGN  = 5'd16;
	localparam kind_t TK_EQ      = 5'd17;
	localparam kind_t TK_NE      = 5'd18;
	localparam kind_t TK_LT      = 5'd19;
	localparam kind_t TK_LE      = 5'd20;
	localparam kind_t TK_GT      = 5'd21;
	localparam kind_t TK_GE      = 5'd22;
	localparam kind_t TK_PERCENT = 5'd23;
	localparam kind_t TK_IDENT   = 5'd24;
	localparam kind_t TK_ERROR   = 5'd25;
	localparam kind_t TK_NONE    = 5'd31;

	// held operator characters
	localparam op_t OP_NONE = 3'd0;
	localparam op_t OP_BANG = 3'd1;
	localparam op_t OP_EQ   = 3'd2;
	localparam op_t OP_LT   = 3'd3;
	localparam op_t OP_GT   = 3'd4;
	localparam op_t OP_AMP  = 3'd5;
	localparam op_t OP_BAR  = 3'd6;

	// keyword prefix tracking
	localparam kw_t KW_NONE   = 4'd0;
	localparam kw_t KW_R      = 4'd1;
	localparam kw_t KW_RETURN = 4'd6;
	localparam kw_t KW_I      = 4'd7;
	localparam kw_t KW_INT    = 4'd9;

	localparam logic [7:0] CH_ZERO = 8'd48;
	localparam logic [7:0] CH_NINE = 8'd57;
	localparam logic [7:0] CH_LF   = 8'h0a;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_input;
	} ctok_in_t;

	typedef struct packed {
		logic [4:0]  token_kind;
		logic [31:0] token_start;
		logic [7:0]  token_length;
		logic [31:0] literal_value;
		logic        last_of_run;
	} ctok_out_t;

	// tokens handed from the lexer to the output queue in the same cycle
	typedef struct packed {
		logic [1:0] cnt;
		ctok_out_t  tok0;
		ctok_out_t  tok1;
	} ctok_push_t;

	function automatic kind_t punct_kind(input logic [7:0] ch);
		kind_t k;
		case (ch)
			"{":     k = TK_LBRACE;
			"}":     k = TK_RBRACE;
			"(":     k = TK_LPAREN;
			")":     k = TK_RPAREN;
			";":     k = TK_SEMI;
			"-":     k = TK_MINUS;
			"~":     k = TK_TILDE;
			"+":     k = TK_PLUS;
			"*":     k = TK_STAR;
			"/":     k = TK_SLASH;
			"%":     k = TK_PERCENT;
			default: k = TK_NONE;
		endcase
		return k;
	endfunction

	function automatic op_t op_code(input logic [7:0] ch);
		op_t p;
		case (ch)
			"!":     p = OP_BANG;
			"=":     p = OP_EQ;
			"<":     p = OP_LT;
			">":     p = OP_GT;
			"&":     p = OP_AMP;
			"|":     p = OP_BAR;
			default: p = OP_NONE;
		endcase
		return p;
	endfunction

	function automatic kind_t single_kind(input op_t p);
		kind_t k;
		case (p)
			OP_BANG: k = TK_NOT;
			OP_EQ:   k = TK_ASSIGN;
			OP_LT:   k = TK_LT;
			OP_GT:   k = TK_GT;
			OP_AMP:  k = TK_ERROR;
			OP_BAR:  k = TK_ERROR;
			default: k = TK_NONE;
		endcase
		return k;
	endfunction

	function automatic kind_t pair_kind(input op_t p, input logic [7:0] ch);
		kind_t k;
		k = TK_NONE;
		case (p)
			OP_BANG: if (ch == "=") k = TK_NE;
			OP_EQ:   if (ch == "=") k = TK_EQ;
			OP_LT:   if (ch == "=") k = TK_LE;
			OP_GT:   if (ch == "=") k = TK_GE;
			OP_AMP:  if (ch == "&") k = TK_AND;
			OP_BAR:  if (ch == "|") k = TK_OR;
			default: k = TK_NONE;
		endcase
		return k;
	endfunction

endpackage

// ===== rtl/ctok_lex.sv =====
// input register, lexer state and per-byte token logic
// depends on ctok_pkg and c_subset_tokenizer_core_defines.svh
`include "c_subset_tokenizer_core_defines.svh"

module ctok_lex (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_stall,
	input  ctok_pkg::ctok_in_t    char_data,
	input  logic [1:0]            room,
	output ctok_pkg::ctok_push_t  push
);

	logic                         valid_s1;
	ctok_pkg::ctok_in_t           data_s1;

	logic                         word_active_q;
	logic                         word_digits_q;
	ctok_pkg::kw_t                kw_q;
	logic [ctok_pkg::POS_W-1:0]   word_start_q;
	logic [ctok_pkg::LEN_W-1:0]   word_len_q;
	logic [31:0]                  acc_q;
	ctok_pkg::op_t                pend_op_q;
	logic [ctok_pkg::POS_W-1:0]   pend_pos_q;
	logic [ctok_pkg::POS_W-1:0]   stream_pos_q;

	logic [7:0]                   ch;
	logic                         eoi;
	logic [ctok_pkg::POS_W-1:0]   pos;
	logic                         is_digit;
	logic                         is_word;
	logic                         is_sep;
	ctok_pkg::kind_t              pk;
	ctok_pkg::op_t                opc;
	ctok_pkg::kind_t              dk;
	ctok_pkg::kind_t              sk;
	logic                         proc;
	ctok_pkg::op_t                p_mid;

	logic                         wa_u;
	logic                         wd_u;
	ctok_pkg::kw_t                kw_u;
	logic [ctok_pkg::POS_W-1:0]   ws_u;
	logic [ctok_pkg::LEN_W-1:0]   wl_u;
	logic [31:0]                  acc_u;
	logic [ctok_pkg::LEN_W-1:0]   wl_base;
	logic [31:0]                  acc_base;
	logic [35:0]                  acc_wide;
	logic                         w_valid;
	ctok_pkg::kind_t              w_kind;

	ctok_pkg::ctok_out_t          cand [4];
	logic [3:0]                   cv;
	logic [1:0]                   n;
	ctok_pkg::ctok_out_t          tok0;
	ctok_pkg::ctok_out_t          tok1;
	logic                         go;

	// next keyword prefix state for one more word character
	function automatic ctok_pkg::kw_t next_kw(input ctok_pkg::kw_t s, input logic [7:0] c,
			input logic first);
		logic [7:0]     expect_ch;
		ctok_pkg::kw_t  r;
		case (s)
			4'd1:    expect_ch = "e";
			4'd2:    expect_ch = "t";
			4'd3:    expect_ch = "u";
			4'd4:    expect_ch = "r";
			4'd5:    expect_ch = "n";
			4'd7:    expect_ch = "n";
			4'd8:    expect_ch = "t";
			default: expect_ch = 8'd0;
		endcase
		if (first) begin
			r = (c == "r") ? ctok_pkg::KW_R : ((c == "i") ? ctok_pkg::KW_I : ctok_pkg::KW_NONE);
		end else if (expect_ch != 8'd0 && c == expect_ch) begin
			r = 4'(s + 4'd1);
		end else begin
			r = ctok_pkg::KW_NONE;
		end
		return r;
	endfunction

	always_comb begin
		ch       = data_s1.char_byte;
		eoi      = data_s1.end_of_input;
		pos      = stream_pos_q;
		is_digit = ch inside {[ctok_pkg::CH_ZERO:ctok_pkg::CH_NINE]};
		is_word  = is_digit || (ch inside {["A":"Z"], ["a":"z"]}) || ch == "_";
		is_sep   = ch == " " || ch == ctok_pkg::CH_LF;
		pk       = ctok_pkg::punct_kind(ch);
		opc      = ctok_pkg::op_code(ch);
		dk       = ctok_pkg::pair_kind(pend_op_q, ch);
		sk       = ctok_pkg::single_kind(pend_op_q);
		// a completed pair swallows this byte
		proc     = dk == ctok_pkg::TK_NONE;

		// held operator, paired or flushed alone
		cand[0]               = '0;
		cand[0].token_kind    = proc ? sk : dk;
		cand[0].token_start   = 32'(pend_pos_q);
		cand[0].token_length  = proc ? 8'd1 : 8'd2;
		cv[0]                 = !proc || sk != ctok_pkg::TK_NONE;

		// word state including this byte if it extends the word
		wa_u     = word_active_q;
		wd_u     = word_digits_q;
		kw_u     = kw_q;
		ws_u     = word_start_q;
		wl_u     = word_len_q;
		acc_u    = acc_q;
		wl_base  = word_active_q ? word_len_q : '0;
		acc_base = word_active_q ? acc_q : '0;
		acc_wide = ({4'd0, acc_base} << 3) + ({4'd0, acc_base} << 1) + 36'(ch[3:0]);
		if (proc && is_word) begin
			wa_u  = 1'b1;
			if (!word_active_q) begin
				ws_u = pos;
			end
			kw_u  = next_kw(kw_q, ch, !word_active_q);
			wl_u  = (wl_base < ctok_pkg::LEN_W'(ctok_pkg::LEN_MAX)) ?
				ctok_pkg::LEN_W'(wl_base + 1'b1) : wl_base;
			if (is_digit) begin
				wd_u  = word_active_q ? word_digits_q : 1'b1;
				acc_u = (acc_wide[35:32] != 4'd0) ? 32'hffff_ffff : acc_wide[31:0];
			end else begin
				wd_u  = 1'b0;
				acc_u = acc_base;
			end
		end

		w_valid = wa_u && ((proc && (is_sep || pk != ctok_pkg::TK_NONE ||
			opc != ctok_pkg::OP_NONE)) || eoi);
		if (kw_u == ctok_pkg::KW_RETURN) begin
			w_kind = ctok_pkg::TK_RETURN;
		end else if (kw_u == ctok_pkg::KW_INT) begin
			w_kind = ctok_pkg::TK_INT;
		end else if (wd_u) begin
			w_kind = ctok_pkg::TK_LITERAL;
		end else begin
			w_kind = ctok_pkg::TK_IDENT;
		end
		cand[1]               = '0;
		cand[1].token_kind    = w_kind;
		cand[1].token_start   = 32'(ws_u);
		cand[1].token_length  = 8'(wl_u);
		cand[1].literal_value = (w_kind == ctok_pkg::TK_LITERAL) ? acc_u : 32'd0;
		cv[1]                 = w_valid;

		cand[2]               = '0;
		cand[2].token_kind    = pk;
		cand[2].token_start   = 32'(pos);
		cand[2].token_length  = 8'd1;
		cv[2]                 = proc && pk != ctok_pkg::TK_NONE;

		// operator started by this byte, flushed at end of input
		p_mid                 = (proc && opc != ctok_pkg::OP_NONE) ? opc : ctok_pkg::OP_NONE;
		cand[3]               = '0;
		cand[3].token_kind    = ctok_pkg::single_kind(p_mid);
		cand[3].token_start   = 32'(pos);
		cand[3].token_length  = 8'd1;
		cv[3]                 = eoi && p_mid != ctok_pkg::OP_NONE;

		// keep the first two candidates in order
		n    = 2'd0;
		tok0 = '0;
		tok1 = '0;
		for (int i = 0; i < 4; i++) begin
			if (cv[i]) begin
				if (n == 2'd0) begin
					tok0 = cand[i];
				end else if (n == 2'd1) begin
					tok1 = cand[i];
				end
				if (n != 2'd2) begin
					n = n + 2'd1;
				end
			end
		end
		if (n == 2'd1) begin
			tok0.last_of_run = 1'b1;
		end
		if (n == 2'd2) begin
			tok1.last_of_run = 1'b1;
		end

		go         = valid_s1 && (n <= room);
		char_stall = valid_s1 && !go;
		push.cnt   = go ? n : 2'd0;
		push.tok0  = tok0;
		push.tok1  = tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_valid && !char_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			data_s1 <= char_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_active_q <= 1'b0;
			word_digits_q <= 1'b1;
			kw_q          <= ctok_pkg::KW_NONE;
			word_start_q  <= '0;
			word_len_q    <= '0;
			acc_q         <= '0;
			pend_op_q     <= ctok_pkg::OP_NONE;
			pend_pos_q    <= '0;
			stream_pos_q  <= '0;
		end else if (go) begin
			word_start_q <= ws_u;
			if (w_valid) begin
				word_active_q <= 1'b0;
				word_digits_q <= 1'b1;
				kw_q          <= ctok_pkg::KW_NONE;
				word_len_q    <= '0;
				acc_q         <= '0;
			end else begin
				word_active_q <= wa_u;
				word_digits_q <= wd_u;
				kw_q          <= kw_u;
				word_len_q    <= wl_u;
				acc_q         <= acc_u;
			end
			pend_op_q <= eoi ? ctok_pkg::OP_NONE : p_mid;
			if (p_mid != ctok_pkg::OP_NONE) begin
				pend_pos_q <= pos;
			end
			stream_pos_q <= eoi ? '0 : ctok_pkg::POS_W'(pos + 1'b1);
		end
	end

	`CTOK_ASSERT(a_len_tracks_word, word_active_q == (word_len_q != '0), "word length out of step with word activity")
	`CTOK_ASSERT_NEXT(a_s1_holds, valid_s1 && !go, valid_s1 && $stable(data_s1), "stalled input register changed")
	`CTOK_ASSERT(a_push_needs_item, (push.cnt == 2'd0) || valid_s1, "tokens pushed without a registered byte")

endmodule

// ===== rtl/ctok_outq.sv =====
// two-entry token queue driving the result channel
// depends on ctok_pkg and c_subset_tokenizer_core_defines.svh
`include "c_subset_tokenizer_core_defines.svh"

module ctok_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctok_pkg::ctok_push_t  push,
	output logic [1:0]            room,
	output logic                  tok_valid,
	input  logic                  tok_stall,
	output ctok_pkg::ctok_out_t   tok_data
);

	ctok_pkg::ctok_out_t  slot_q [2];
	logic                 rd_q;
	logic                 wr_q;
	logic [1:0]           cnt_q;
	logic                 pop;

	assign tok_valid = cnt_q != 2'd0;
	assign tok_data  = slot_q[rd_q];
	assign pop       = tok_valid && !tok_stall;
	// a token leaving this cycle frees its slot for the lexer
	assign room      = 2'd2 - cnt_q + {1'b0, pop};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			rd_q  <= rd_q ^ pop;
			wr_q  <= wr_q ^ push.cnt[0];
			cnt_q <= cnt_q + push.cnt - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			slot_q[wr_q] <= push.tok0;
		end
		if (push.cnt == 2'd2) begin
			slot_q[~wr_q] <= push.tok1;
		end
	end

	`CTOK_ASSERT(a_cnt_range, cnt_q != 2'd3, "token queue count out of range")
	`CTOK_ASSERT(a_no_overflow, push.cnt <= room, "more tokens pushed than the queue can hold")
	`CTOK_ASSERT_NEXT(a_push_shows, (cnt_q == 2'd0) && (push.cnt != 2'd0), tok_valid, "pushed token not presented")

endmodule

// ===== rtl/c_subset_tokenizer_core.sv =====
// tokenizer for a small c subset, one source byte per request
// usage notes below; depends on ctok_pkg, ctok_lex and ctok_outq
//
// char channel: one byte per request (char_data.char_byte), with
//   char_data.end_of_input marking the last byte of a source stream;
//   pending word and held operator are flushed on that byte and the
//   byte position counter restarts at zero for the next stream
// tok channel: one token per request (kind, start, length, literal
//   value); last_of_run marks the final token caused by a given byte
// a byte may cause zero, one or two tokens
// an accepted byte is held in the input register and decoded there; its
//   tokens are written into the token queue, which offers them on tok_valid
// throughput: one byte per cycle while the token queue has room; the result
//   port moves one token per cycle while tok_stall is low, and the tokens of a
//   byte giving two are held in the two-slot token queue in front of the tok channel
// stall on tok backs up into the queue; once the queue cannot take the
//   tokens of the registered byte, char_stall rises until it can
// reset: no pending word or operator, queue empty, position zero

module c_subset_tokenizer_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_stall,
	input  ctok_pkg::ctok_in_t   char_data,
	output logic                 tok_valid,
	input  logic                 tok_stall,
	output ctok_pkg::ctok_out_t  tok_data
);

	ctok_pkg::ctok_push_t  push;
	logic [1:0]            room;

	ctok_lex u_lex (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.room       (room),
		.push       (push)
	);

	ctok_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_data  (tok_data)
	);

endmodule

// ===== tb/c_subset_tokenizer_core_tb.sv =====
// self-checking testbench for c_subset_tokenizer_core: byte streams go in on the char channel,
// tokens are checked against a lexer model kept in this file
// depends on ctok_pkg and the tokenizer rtl
module c_subset_tokenizer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS       = 1450;
	localparam int QUIET_LIMIT = 2000;
	localparam int REPORT_MAX  = 10;
	localparam int TAIL_CYCLES = 20;
	localparam logic [47:0] RETURN_TXT = "return";
	localparam logic [23:0] INT_TXT    = "int";

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                char_valid = 1'b0;
	logic                char_stall;
	ctok_pkg::ctok_in_t  char_data  = '0;
	logic                tok_valid;
	logic                tok_stall  = 1'b0;
	ctok_pkg::ctok_out_t tok_data;

	c_subset_tokenizer_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.tok_valid  (tok_valid),
		.tok_stall  (tok_stall),
		.tok_data   (tok_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// stimulus and expected tokens
	ctok_pkg::ctok_in_t   byte_q[$];
	logic [7:0]           text_q[$];
	ctok_pkg::ctok_out_t  tokens_due[$];

	// lexer model state
	bit                   w_active  = 1'b0;
	bit                   w_digits  = 1'b1;
	ctok_pkg::kw_t        w_kw      = ctok_pkg::KW_NONE;
	logic [31:0]          w_start   = '0;
	logic [7:0]           w_len     = '0;
	logic [31:0]          w_value   = '0;
	ctok_pkg::op_t        held_op   = ctok_pkg::OP_NONE;
	logic [31:0]          held_pos  = '0;
	logic [31:0]          byte_pos  = '0;
	ctok_pkg::ctok_out_t  step_tok[2];
	int                   step_cnt;

	// handshake bookkeeping
	bit char_taken   = 1'b0;
	bit tok_taken    = 1'b0;
	bit tx_burst     = 1'b0;
	bit rx_burst     = 1'b0;
	int sent_cnt     = 0;
	int seen_cnt     = 0;
	int tx_gap       = 0;
	int rx_wait      = 0;
	int hold_left    = 0;
	int quiet_cycles = 0;
	int mismatch_cnt = 0;

	task automatic emit_tok(input ctok_pkg::kind_t k, input logic [31:0] start,
			input logic [7:0] len, input logic [31:0] val);
		ctok_pkg::ctok_out_t t;
		if (step_cnt < 2) begin
			t.token_kind    = k;
			t.token_start   = start;
			t.token_length  = len;
			t.literal_value = val;
			t.last_of_run   = 1'b0;
			step_tok[step_cnt] = t;
			step_cnt++;
		end
	endtask

	task automatic flush_word();
		ctok_pkg::kind_t k;
		if (w_active) begin
			if (w_kw == ctok_pkg::KW_RETURN)
				k = ctok_pkg::TK_RETURN;
			else if (w_kw == ctok_pkg::KW_INT)
				k = ctok_pkg::TK_INT;
			else if (w_digits)
				k = ctok_pkg::TK_LITERAL;
			else
				k = ctok_pkg::TK_IDENT;
			emit_tok(k, w_start, w_len, (k == ctok_pkg::TK_LITERAL) ? w_value : 32'd0);
			w_active = 1'b0;
			w_digits = 1'b1;
			w_kw     = ctok_pkg::KW_NONE;
			w_len    = '0;
			w_value  = '0;
		end
	endtask

	task automatic flush_held();
		ctok_pkg::kind_t k;
		case (held_op)
			ctok_pkg::OP_BANG: k = ctok_pkg::TK_NOT;
			ctok_pkg::OP_EQ:   k = ctok_pkg::TK_ASSIGN;
			ctok_pkg::OP_LT:   k = ctok_pkg::TK_LT;
			ctok_pkg::OP_GT:   k = ctok_pkg::TK_GT;
			ctok_pkg::OP_AMP:  k = ctok_pkg::TK_ERROR;
			ctok_pkg::OP_BAR:  k = ctok_pkg::TK_ERROR;
			default:           k = ctok_pkg::TK_NONE;
		endcase
		if (k != ctok_pkg::TK_NONE)
			emit_tok(k, held_pos, 8'd1, 32'd0);
		held_op = ctok_pkg::OP_NONE;
	endtask

	// keyword prefix tracker: states walk the letters of return and int
	function automatic ctok_pkg::kw_t kw_step(input ctok_pkg::kw_t s, input logic [7:0] ch,
			input bit first);
		ctok_pkg::kw_t nx;
		nx = ctok_pkg::KW_NONE;
		if (first) begin
			if (ch == "r")
				nx = ctok_pkg::KW_R;
			else if (ch == "i")
				nx = ctok_pkg::KW_I;
		end else if (s >= ctok_pkg::KW_R && s < ctok_pkg::KW_RETURN) begin
			if (ch == RETURN_TXT[8 * (ctok_pkg::KW_RETURN - 1 - s) +: 8])
				nx = s + 1'b1;
		end else if (s >= ctok_pkg::KW_I && s < ctok_pkg::KW_INT) begin
			if (ch == INT_TXT[8 * (ctok_pkg::KW_INT - 1 - s) +: 8])
				nx = s + 1'b1;
		end
		return nx;
	endfunction

	task automatic take_char(input logic [7:0] ch, input logic [31:0] pos);
		bit              digit;
		bit              alpha;
		bit              first;
		ctok_pkg::kind_t k;
		ctok_pkg::op_t   p;
		logic [35:0]     acc;
		digit = (ch >= ctok_pkg::CH_ZERO) && (ch <= ctok_pkg::CH_NINE);
		alpha = (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
		if (digit || alpha || ch == "_") begin
			first = !w_active;
			if (first) begin
				w_active = 1'b1;
				w_start  = pos;
				w_len    = '0;
				w_digits = 1'b1;
				w_value  = '0;
			end
			w_kw = kw_step(w_kw, ch, first);
			if (w_len < ctok_pkg::LEN_MAX)
				w_len++;
			if (digit) begin
				acc = w_value * 36'd10 + (ch - ctok_pkg::CH_ZERO);
				w_value = (acc > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
			end else begin
				w_digits = 1'b0;
			end
		end else if (ch == " " || ch == ctok_pkg::CH_LF) begin
			flush_word();
		end else begin
			k = ctok_pkg::TK_NONE;
			p = ctok_pkg::OP_NONE;
			case (ch)
				"{": k = ctok_pkg::TK_LBRACE;
				"}": k = ctok_pkg::TK_RBRACE;
				"(": k = ctok_pkg::TK_LPAREN;
				")": k = ctok_pkg::TK_RPAREN;
				";": k = ctok_pkg::TK_SEMI;
				"-": k = ctok_pkg::TK_MINUS;
				"~": k = ctok_pkg::TK_TILDE;
				"+": k = ctok_pkg::TK_PLUS;
				"*": k = ctok_pkg::TK_STAR;
				"/": k = ctok_pkg::TK_SLASH;
				"%": k = ctok_pkg::TK_PERCENT;
				"!": p = ctok_pkg::OP_BANG;
				"=": p = ctok_pkg::OP_EQ;
				"<": p = ctok_pkg::OP_LT;
				">": p = ctok_pkg::OP_GT;
				"&": p = ctok_pkg::OP_AMP;
				"|": p = ctok_pkg::OP_BAR;
				default: ;
			endcase
			if (k != ctok_pkg::TK_NONE) begin
				flush_word();
				emit_tok(k, pos, 8'd1, 32'd0);
			end else if (p != ctok_pkg::OP_NONE) begin
				flush_word();
				held_op  = p;
				held_pos = pos;
			end
		end
	endtask

	// tokens caused by one accepted byte, queued in order
	task automatic lex_byte(input ctok_pkg::ctok_in_t b);
		ctok_pkg::kind_t     pk;
		bit                  used;
		logic [31:0]         pos;
		ctok_pkg::ctok_out_t t;
		step_cnt = 0;
		used     = 1'b0;
		pos      = byte_pos;
		if (held_op != ctok_pkg::OP_NONE) begin
			pk = ctok_pkg::TK_NONE;
			if (b.char_byte == "=") begin
				case (held_op)
					ctok_pkg::OP_BANG: pk = ctok_pkg::TK_NE;
					ctok_pkg::OP_EQ:   pk = ctok_pkg::TK_EQ;
					ctok_pkg::OP_LT:   pk = ctok_pkg::TK_LE;
					ctok_pkg::OP_GT:   pk = ctok_pkg::TK_GE;
					default:           pk = ctok_pkg::TK_NONE;
				endcase
			end else if (b.char_byte == "&" && held_op == ctok_pkg::OP_AMP) begin
				pk = ctok_pkg::TK_AND;
			end else if (b.char_byte == "|" && held_op == ctok_pkg::OP_BAR) begin
				pk = ctok_pkg::TK_OR;
			end
			if (pk != ctok_pkg::TK_NONE) begin
				emit_tok(pk, held_pos, 8'd2, 32'd0);
				held_op = ctok_pkg::OP_NONE;
				used    = 1'b1;
			end else begin
				flush_held();
			end
		end
		if (!used)
			take_char(b.char_byte, pos);
		if (b.end_of_input) begin
			flush_word();
			flush_held();
			byte_pos = '0;
		end else begin
			byte_pos = 32'(pos + 32'd1);
		end
		for (int i = 0; i < step_cnt; i++) begin
			t = step_tok[i];
			t.last_of_run = (i == step_cnt - 1);
			tokens_due.push_back(t);
		end
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endtask

	task automatic close_stream(input bit eoi_last);
		ctok_pkg::ctok_in_t b;
		for (int i = 0; i < text_q.size(); i++) begin
			b.char_byte    = text_q[i];
			b.end_of_input = eoi_last && (i == text_q.size() - 1);
			byte_q.push_back(b);
		end
		text_q.delete();
	endtask

	function automatic logic [7:0] word_char(input bit no_digit);
		int         r;
		logic [7:0] c;
		r = $urandom_range(0, no_digit ? 52 : 62);
		if (r < 26)
			c = 8'("a" + r);
		else if (r < 52)
			c = 8'("A" + (r - 26));
		else if (r == 52)
			c = "_";
		else
			c = 8'("0" + (r - 53));
		return c;
	endfunction

	task automatic add_piece();
		string      punct;
		string      opch;
		int         sel;
		int         n;
		logic [7:0] c;
		punct = "{}();-~+*/%";
		opch  = "!=<>&|";
		sel   = $urandom_range(0, 99);
		if (sel < 15) begin
			text_q.push_back(word_char(1'b1));
			n = $urandom_range(0, 7);
			repeat (n) text_q.push_back(word_char(1'b0));
		end else if (sel < 23) begin
			case ($urandom_range(0, 7))
				0: add_text("int");
				1: add_text("return");
				2: add_text("in");
				3: add_text("retur");
				4: add_text("intx");
				5: add_text("returns");
				6: add_text("4294967295");
				default: add_text("4294967296");
			endcase
		end else if (sel < 35) begin
			n = $urandom_range(1, 12);
			repeat (n) text_q.push_back(8'("0" + $urandom_range(0, 9)));
		end else if (sel < 50) begin
			text_q.push_back(punct[$urandom_range(0, 10)]);
		end else if (sel < 64) begin
			c = opch[$urandom_range(0, 5)];
			text_q.push_back(c);
			case ($urandom_range(0, 3))
				0: text_q.push_back("=");
				1: text_q.push_back(c);
				2: text_q.push_back(opch[$urandom_range(0, 5)]);
				default: ;
			endcase
		end else if (sel < 90) begin
			text_q.push_back(($urandom_range(0, 3) != 0) ? " " : "\n");
		end else begin
			text_q.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// char side: holds each request until it is taken, then waits a drawn gap
	always @(negedge clk) begin : drive_chars
		bit done;
		if (arst_n) begin
			done = char_taken;
			char_taken = 1'b0;
			if (done) begin
				sent_cnt++;
				if (sent_cnt % 64 == 0)
					tx_burst = ($urandom_range(0, 3) == 0);
				tx_gap = tx_burst ? 0 : $urandom_range(0, 6);
			end
			if (char_valid && !done) begin
				// stalled request stays as it is
			end else if (tx_gap > 0) begin
				tx_gap--;
				char_valid <= 1'b0;
			end else if (byte_q.size() != 0) begin
				char_data  <= byte_q.pop_front();
				char_valid <= 1'b1;
			end else begin
				char_valid <= 1'b0;
			end
		end
	end

	// token side stall: a drawn wait after each token, plus two long hold-offs
	always @(negedge clk) begin : drive_stall
		if (arst_n) begin
			if (tok_taken) begin
				tok_taken = 1'b0;
				seen_cnt++;
				if (seen_cnt % 50 == 0)
					rx_burst = ($urandom_range(0, 3) == 0);
				rx_wait = rx_burst ? 0 : $urandom_range(0, 6);
				// long enough for the token queue to fill and back up the char side
				if (seen_cnt == 100 || seen_cnt == 400)
					hold_left = 200;
			end
			if (hold_left > 0) begin
				hold_left--;
				tok_stall <= 1'b1;
			end else if (rx_wait > 0) begin
				rx_wait--;
				tok_stall <= 1'b1;
			end else begin
				tok_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch_ports
		ctok_pkg::ctok_out_t want;
		bit                  moved;
		if (arst_n) begin
			moved = 1'b0;
			if (tok_valid && !tok_stall) begin
				tok_taken = 1'b1;
				moved = 1'b1;
				if (tokens_due.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= REPORT_MAX)
						$display("%0t: unexpected token kind %0d start %0d len %0d",
							$realtime, tok_data.token_kind, tok_data.token_start,
							tok_data.token_length);
				end else begin
					want = tokens_due.pop_front();
					if (tok_data.token_kind !== want.token_kind ||
							tok_data.token_start !== want.token_start ||
							tok_data.token_length !== want.token_length ||
							tok_data.literal_value !== want.literal_value ||
							tok_data.last_of_run !== want.last_of_run) begin
						mismatch_cnt++;
						if (mismatch_cnt <= REPORT_MAX)
							$display({"%0t: token mismatch (exp/act) kind %0d/%0d start %0d/%0d",
								" len %0d/%0d value %0d/%0d last %0b/%0b"}, $realtime,
								want.token_kind, tok_data.token_kind,
								want.token_start, tok_data.token_start,
								want.token_length, tok_data.token_length,
								want.literal_value, tok_data.literal_value,
								want.last_of_run, tok_data.last_of_run);
					end
				end
			end
			if (char_valid && !char_stall) begin
				char_taken = 1'b1;
				moved = 1'b1;
				lex_byte(char_data);
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int long_done;
		int n;
		bit timed_out;
		long_done = 0;
		timed_out = 1'b0;

		// keyword, identifier, literal, held = followed by a digit, ignored bytes inside a stream
		add_text("int r2=0;");
		text_q.push_back(8'h00);
		text_q.push_back(8'hff);
		text_q.push_back(8'h80);
		text_q.push_back(8'h7f);
		text_q.push_back("\t");
		close_stream(1'b0);
		// lone ampersand and bar, then a held bang flushed at end of input
		add_text("a&|b!");
		close_stream(1'b1);
		// word still open at end of input
		add_text("return");
		close_stream(1'b1);

		while (byte_q.size() < ITEMS) begin
			n = $urandom_range(1, 30);
			repeat (n) add_piece();
			// two words past the length limit: one identifier, one literal
			if (long_done < 2 && byte_q.size() > 500 * (long_done + 1)) begin
				text_q.push_back(" ");
				n = $urandom_range(256, 300);
				repeat (n) text_q.push_back((long_done == 0) ? word_char(1'b1) :
					8'("0" + $urandom_range(0, 9)));
				text_q.push_back(";");
				long_done++;
			end
			close_stream($urandom_range(0, 9) != 0);
		end

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		while (!timed_out &&
				(byte_q.size() != 0 || char_valid || tokens_due.size() != 0)) begin
			@(negedge clk);
			if (quiet_cycles >= QUIET_LIMIT)
				timed_out = 1'b1;
		end
		if (!timed_out)
			repeat (TAIL_CYCLES) @(posedge clk);
		if (!timed_out && mismatch_cnt == 0 && tokens_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
